// ===== hw/rtl/cpfr_pkg.sv =====
// Shared types and constants for the climb phase force regulator.
package cpfr_pkg;

	// Number of samples spent in the hold phase before stopping
	localparam int unsigned HOLD_ITEMS = 200;
	localparam int unsigned HOLD_W     = 8;

	// Roll at which force regulation ends: 178.0 degrees in Q8.8
	localparam logic signed [16:0] ROLL_END_Q8 = 17'sd45568;
	// End-of-climb speed: 0.4 in Q8.8, truncated
	localparam logic [15:0] END_SPEED_Q8 = 16'd102;

	// Configuration port widths
	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned CFG_DATA_W = 17;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CRUISE_SPEED    = 4'd0,
		REG_EDGE_DISTANCE   = 4'd1,
		REG_LIFT_ROLL_LIMIT = 4'd2,
		REG_LIFT_VOLTAGE    = 4'd3,
		REG_FORCE_TARGET    = 4'd4,
		REG_FORCE_GAIN      = 4'd5,
		REG_VOLTAGE_CAP     = 4'd6,
		REG_FORCE_DEADBAND  = 4'd7
	} reg_idx_t;

	// Sequencer phases
	typedef enum logic [2:0] {
		PH_CRUISE   = 3'd0,
		PH_LIFT     = 3'd1,
		PH_REGULATE = 3'd2,
		PH_HOLD     = 3'd3,
		PH_STOP     = 3'd4
	} phase_t;

	// Actuator direction codes
	typedef enum logic [1:0] {
		DIR_RAISE = 2'd0,
		DIR_LOWER = 2'd1,
		DIR_STOP  = 2'd2
	} dir_t;

	// One sensor sample
	typedef struct packed {
		logic signed [16:0] roll_angle;
		logic [15:0]        edge_range;
		logic signed [15:0] measured_force;
	} sample_t;

	// One drive command
	typedef struct packed {
		logic [15:0] speed_cmd;
		logic [15:0] voltage_cmd;
		logic [1:0]  direction_cmd;
		logic [2:0]  phase_now;
	} command_t;

endpackage

// ===== hw/rtl/climb_phase_force_regulator.sv =====
// Climb phase sequencer with proportional force regulation, one command per sample.
// Sample path: a sample transfer loads the sample register; its command loads
//   into the command register once that register is free (no cmd_stall held).
// Throughput: one sample per cycle unless cmd_stall holds the command register;
//   the sample-to-command path (16x16 multiply, saturate, cap) is combinational.
// Reset (arst_n low, asynchronous): phase to cruise, hold count to 0, all
//   configuration registers to 0, both pipeline registers empty.
module climb_phase_force_regulator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  cpfr_pkg::sample_t                   sample,
	output logic                                cmd_valid,
	input  logic                                cmd_stall,
	output cpfr_pkg::command_t                  cmd,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cpfr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cpfr_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import cpfr_pkg::*;

	// Configuration registers
	logic [15:0]        cruise_speed_q;
	logic [15:0]        edge_distance_q;
	logic signed [16:0] lift_roll_limit_q;
	logic [15:0]        lift_voltage_q;
	logic signed [15:0] force_target_q;
	logic [15:0]        force_gain_q;
	logic [15:0]        voltage_cap_q;
	logic [15:0]        force_deadband_q;

	// Sequencer state
	phase_t            phase_q, phase_d;
	logic [HOLD_W-1:0] hold_q, hold_d;

	// Pipeline
	logic     valid_s1;
	sample_t  sample_s1;
	logic     cmd_valid_q;
	command_t cmd_q;
	logic     advance;
	logic     fire_s1;

	// Regulation datapath
	logic signed [16:0] err;
	logic [16:0]        mag_full;
	logic [15:0]        mag;
	logic [31:0]        prod;
	logic [19:0]        prod_q12;
	logic [15:0]        volt_sat;
	logic [15:0]        volt_reg;
	logic               drive_on;
	logic               roll_end;

	command_t cmd_d;

	assign cfg_ready = 1'b1;

	// Configuration writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cruise_speed_q    <= '0;
			edge_distance_q   <= '0;
			lift_roll_limit_q <= '0;
			lift_voltage_q    <= '0;
			force_target_q    <= '0;
			force_gain_q      <= '0;
			voltage_cap_q     <= '0;
			force_deadband_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_CRUISE_SPEED:    cruise_speed_q    <= cfg_data[15:0];
				REG_EDGE_DISTANCE:   edge_distance_q   <= cfg_data[15:0];
				REG_LIFT_ROLL_LIMIT: lift_roll_limit_q <= cfg_data[16:0];
				REG_LIFT_VOLTAGE:    lift_voltage_q    <= cfg_data[15:0];
				REG_FORCE_TARGET:    force_target_q    <= cfg_data[15:0];
				REG_FORCE_GAIN:      force_gain_q      <= cfg_data[15:0];
				REG_VOLTAGE_CAP:     voltage_cap_q     <= cfg_data[15:0];
				REG_FORCE_DEADBAND:  force_deadband_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Handshake: the sample stage moves on whenever the command register is free
	assign advance      = !cmd_valid_q || !cmd_stall;
	assign fire_s1      = valid_s1 && advance;
	assign sample_stall = valid_s1 && !advance;

	// Sample register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			sample_s1 <= sample;
		end
	end

	// Force error, magnitude and proportional drive
	always_comb begin
		err      = 17'(force_target_q) - 17'(sample_s1.measured_force);
		mag_full = err[16] ? 17'(-err) : 17'(err);
		mag      = mag_full[15:0];
		prod     = force_gain_q * mag;
		prod_q12 = prod[31:12];
		volt_sat = (|prod_q12[19:16]) ? 16'hFFFF : prod_q12[15:0];
		volt_reg = (volt_sat > voltage_cap_q) ? voltage_cap_q : volt_sat;
		drive_on = (err != 17'sd0) && (mag > force_deadband_q);
		roll_end = sample_s1.roll_angle >= ROLL_END_Q8;
	end

	// Next phase and hold count
	always_comb begin
		phase_d = phase_q;
		hold_d  = hold_q;
		case (phase_q)
			PH_CRUISE: begin
				if (sample_s1.edge_range > edge_distance_q) phase_d = PH_LIFT;
			end
			PH_LIFT: begin
				if (sample_s1.roll_angle > lift_roll_limit_q) phase_d = PH_REGULATE;
			end
			PH_REGULATE: begin
				if (roll_end) begin
					phase_d = PH_HOLD;
					hold_d  = '0;
				end
			end
			PH_HOLD: begin
				hold_d = hold_q + HOLD_W'(1);
				if (hold_d >= HOLD_W'(HOLD_ITEMS)) begin
					phase_d = PH_STOP;
					hold_d  = '0;
				end
			end
			default: begin
				phase_d = PH_STOP;
			end
		endcase
	end

	// Command fields per phase
	always_comb begin
		cmd_d.speed_cmd     = '0;
		cmd_d.voltage_cmd   = '0;
		cmd_d.direction_cmd = DIR_RAISE;
		cmd_d.phase_now     = phase_d;
		case (phase_q)
			PH_CRUISE: begin
				cmd_d.speed_cmd = cruise_speed_q;
			end
			PH_LIFT: begin
				cmd_d.speed_cmd   = cruise_speed_q;
				cmd_d.voltage_cmd = lift_voltage_q;
			end
			PH_REGULATE: begin
				if (roll_end) begin
					cmd_d.speed_cmd     = END_SPEED_Q8;
					cmd_d.direction_cmd = DIR_STOP;
				end else if (drive_on) begin
					cmd_d.speed_cmd     = cruise_speed_q;
					cmd_d.voltage_cmd   = volt_reg;
					cmd_d.direction_cmd = err[16] ? DIR_LOWER : DIR_RAISE;
				end else begin
					cmd_d.speed_cmd     = cruise_speed_q;
					cmd_d.direction_cmd = DIR_STOP;
				end
			end
			PH_HOLD: ;
			default: begin
				cmd_d.direction_cmd = DIR_STOP;
			end
		endcase
	end

	// Sequencer state moves once per sample leaving the sample register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CRUISE;
			hold_q  <= '0;
		end else if (fire_s1) begin
			phase_q <= phase_d;
			hold_q  <= hold_d;
		end
	end

	// Command register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
		end else if (advance) begin
			cmd_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			cmd_q <= cmd_d;
		end
	end

	assign cmd_valid = cmd_valid_q;
	assign cmd       = cmd_q;

	// Hold count is only in use during the hold phase
	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_HOLD) |-> (hold_q == '0))
		else $error("hold count nonzero outside hold phase");

	// Phase only ever steps forward by one
	a_phase_step: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != $past(phase_q)) |-> (3'(phase_q) == 3'($past(phase_q)) + 3'd1))
		else $error("phase skipped or went back");

	// A new command appears only when a sample was waiting
	a_cmd_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(cmd_valid_q) |-> $past(valid_s1))
		else $error("command without a sample");

	// Actuator voltage only in lift or regulation
	a_volt_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid_q && cmd_q.voltage_cmd != 16'd0) |->
			(cmd_q.phase_now == PH_LIFT || cmd_q.phase_now == PH_REGULATE))
		else $error("voltage driven outside lift or regulation");

endmodule
